// ----- hdl/lpht_pkg.sv -----
// Package for the linear probe hash table: sizes, op codes, bucket record and state enum.
// No dependencies.
`default_nettype none
package lpht_pkg;
	localparam int BUCKETS = 256;
	localparam int IDX_W = $clog2(BUCKETS);
	localparam int CNT_W = 9;

	typedef enum logic [1:0] {
		OP_GET          = 2'd0,
		OP_PUT          = 2'd1,
		OP_PUT_IF_EMPTY = 2'd2,
		OP_REMOVE       = 2'd3
	} op_t;

	typedef struct packed {
		logic [63:0] ka;
		logic [63:0] kb;
		logic [63:0] val;
		logic        in_use;
		logic        removed;
	} bucket_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ----- hdl/lpht_ram.sv -----
// Bucket memory of the hash table: one write port, one registered read port.
// Depends on lpht_pkg.
`default_nettype none
module lpht_ram (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [lpht_pkg::IDX_W-1:0] waddr,
	input  wire lpht_pkg::bucket_t        wdata,
	input  wire logic [lpht_pkg::IDX_W-1:0] raddr,
	output lpht_pkg::bucket_t             rdata
);
	lpht_pkg::bucket_t mem [lpht_pkg::BUCKETS];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- hdl/linear_probe_hash_table_top.sv -----
// Top level of the linear probe hash table: probe sequencer, counters, result register.
// Depends on lpht_pkg and lpht_ram.
//
// channel  direction  handshake        payload
// in       input      in_valid/ready   op, hash_low, hash_high, item_in
// out      output     out_valid/ready  found, item_out, stored, table_full, live_count
// cfg      input      load_limit_we    load_limit_wdata
//
// A request passes IDLE, then READ and CHECK for each bucket probed, then DONE: each probe is a
// memory read and a compare, since the memory read latency sits in the probe loop.
// A request with a zero key probes nothing and goes from READ straight to DONE.
// After reset a clearing pass writes all BUCKETS entries, one per cycle, before the
// first request is taken. A finished result waits in the output register; the next
// request is taken while it waits, but is completed only once that register is free.
`default_nettype none
module linear_probe_hash_table_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  op,
	input  wire logic [63:0] hash_low,
	input  wire logic [63:0] hash_high,
	input  wire logic [63:0] item_in,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             found,
	output logic [63:0]      item_out,
	output logic             stored,
	output logic             table_full,
	output logic [8:0]       live_count,
	input  wire logic        load_limit_we,
	input  wire logic [8:0]  load_limit_wdata
);
	localparam int IW = lpht_pkg::IDX_W;
	localparam int CW = lpht_pkg::CNT_W;

	lpht_pkg::state_t state_q, state_d;
	logic [CW-1:0] limit_q, resv_q, remc_q;
	logic [IW-1:0] ix_q;
	logic [IW:0]   n_q;
	logic [1:0]    op_q;
	logic [63:0]   ha_q, hb_q, it_q;

	logic we;
	logic [IW-1:0] waddr, raddr;
	lpht_pkg::bucket_t wdata, rd;

	lpht_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rd));

	logic zero_key, is_empty, is_match, last_probe, out_free;
	assign zero_key = (ha_q == 64'd0) && (hb_q == 64'd0);
	assign is_empty = (rd.ka == 64'd0) && (rd.kb == 64'd0);
	assign is_match = (rd.ka == ha_q) && (rd.kb == hb_q);
	assign last_probe = (n_q == (IW+1)'(lpht_pkg::BUCKETS - 1));
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == lpht_pkg::ST_IDLE);
	assign raddr = ix_q;

	// Outcome of the finishing probe, and the zeroing writes of the clearing pass.
	logic r_found, r_stored, r_full, inc_resv, inc_rem, dec_rem;
	logic [63:0] r_item;
	always_comb begin
		logic key_hit, fresh;
		key_hit = !is_empty && is_match;
		fresh = is_empty;
		r_found = 1'b0; r_item = 64'd0; r_stored = 1'b0; r_full = 1'b0;
		inc_resv = 1'b0; inc_rem = 1'b0; dec_rem = 1'b0;
		we = 1'b0; waddr = ix_q; wdata = rd;
		if (state_q == lpht_pkg::ST_CLEAR) begin
			we = 1'b1; wdata = '0;
		end else if (state_q == lpht_pkg::ST_DONE && out_free && !zero_key) begin
			unique case (lpht_pkg::op_t'(op_q))
				lpht_pkg::OP_GET, lpht_pkg::OP_REMOVE: begin
					if (key_hit && rd.in_use) begin
						r_found = 1'b1; r_item = rd.val;
						if (op_q == lpht_pkg::OP_REMOVE) begin
							we = 1'b1; wdata.val = 64'd0; wdata.in_use = 1'b0;
							wdata.removed = 1'b1; inc_rem = 1'b1;
						end
					end
				end
				lpht_pkg::OP_PUT, lpht_pkg::OP_PUT_IF_EMPTY: begin
					if (!key_hit && !(fresh && resv_q < limit_q)) begin
						r_full = 1'b1;
					end else if (key_hit && op_q == lpht_pkg::OP_PUT_IF_EMPTY
						&& rd.in_use) begin
						r_found = 1'b1; r_item = rd.val;
					end else begin
						inc_resv = fresh;
						r_found = key_hit && rd.in_use;
						r_item = key_hit ? rd.val : 64'd0;
						if (op_q == lpht_pkg::OP_PUT_IF_EMPTY) begin
							r_stored = 1'b1; r_item = it_q;
						end
						dec_rem = key_hit && rd.removed;
						we = 1'b1;
						wdata.ka = ha_q; wdata.kb = hb_q; wdata.val = it_q;
						wdata.in_use = 1'b1; wdata.removed = 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lpht_pkg::ST_CLEAR:
				if (ix_q == IW'(lpht_pkg::BUCKETS - 1)) state_d = lpht_pkg::ST_IDLE;
			lpht_pkg::ST_IDLE: if (in_valid) state_d = lpht_pkg::ST_READ;
			lpht_pkg::ST_READ: state_d = zero_key ? lpht_pkg::ST_DONE : lpht_pkg::ST_CHECK;
			lpht_pkg::ST_CHECK:
				if (is_empty || is_match || last_probe) state_d = lpht_pkg::ST_DONE;
				else state_d = lpht_pkg::ST_READ;
			lpht_pkg::ST_DONE: if (out_free) state_d = lpht_pkg::ST_IDLE;
			default: state_d = lpht_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpht_pkg::ST_CLEAR;
			limit_q <= CW'(192);
			resv_q <= '0; remc_q <= '0; ix_q <= '0; n_q <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_limit_we) limit_q <= load_limit_wdata;
			if (state_q == lpht_pkg::ST_DONE && out_free) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			unique case (state_q)
				lpht_pkg::ST_CLEAR: ix_q <= ix_q + 1'b1;
				lpht_pkg::ST_IDLE: begin
					ix_q <= hash_low[IW-1:0]; n_q <= '0;
				end
				lpht_pkg::ST_CHECK:
					if (state_d == lpht_pkg::ST_READ) begin
						ix_q <= ix_q + 1'b1; n_q <= n_q + 1'b1;
					end
				lpht_pkg::ST_DONE:
					if (out_free) begin
						resv_q <= resv_q + CW'(inc_resv);
						remc_q <= remc_q + CW'(inc_rem) - CW'(dec_rem);
					end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == lpht_pkg::ST_IDLE && in_valid) begin
			op_q <= op; ha_q <= hash_low; hb_q <= hash_high; it_q <= item_in;
		end
		if (state_q == lpht_pkg::ST_DONE && out_free) begin
			found <= r_found; item_out <= r_item; stored <= r_stored;
			table_full <= r_full;
			live_count <= (resv_q + CW'(inc_resv)) - (remc_q + CW'(inc_rem) - CW'(dec_rem));
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request taken while busy");
	a_resv_mono: assert property (@(posedge clk) disable iff (!arst_n)
		resv_q >= $past(resv_q))
		else $error("reserved count went down");
	a_rem_le_resv: assert property (@(posedge clk) disable iff (!arst_n)
		remc_q <= resv_q)
		else $error("removed count exceeds reserved count");
	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lpht_pkg::ST_DONE && out_free) |=> out_valid)
		else $error("result not presented");
`endif
endmodule
`default_nettype wire

// ----- sim/lpht_result_check.sv -----
// Result checker for the linear probe hash table: watches the request, result and
// load limit ports, keeps its own copy of the table, and compares every result.
// Depends on lpht_pkg.
module lpht_result_check (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  op,
	input  logic [63:0] hash_low,
	input  logic [63:0] hash_high,
	input  logic [63:0] item_in,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        found,
	input  logic [63:0] item_out,
	input  logic        stored,
	input  logic        table_full,
	input  logic [8:0]  live_count,
	input  logic        load_limit_we,
	input  logic [8:0]  load_limit_wdata,
	output int          mismatches,
	output int          pending
);
	typedef struct packed {
		logic        found;
		logic [63:0] item;
		logic        stored;
		logic        full;
		logic [8:0]  live;
	} hash_result_t;

	logic [63:0] key_a [lpht_pkg::BUCKETS];
	logic [63:0] key_b [lpht_pkg::BUCKETS];
	logic [63:0] value [lpht_pkg::BUCKETS];
	logic        used [lpht_pkg::BUCKETS];
	logic        gone [lpht_pkg::BUCKETS];
	int unsigned reserved_cnt;
	int unsigned removed_cnt;
	int unsigned limit;
	hash_result_t awaited [$];

	initial begin
		for (int i = 0; i < lpht_pkg::BUCKETS; i++) begin
			key_a[i] = '0;
			key_b[i] = '0;
			value[i] = '0;
			used[i] = 1'b0;
			gone[i] = 1'b0;
		end
		reserved_cnt = 0;
		removed_cnt = 0;
		limit = 192;
		mismatches = 0;
		pending = 0;
	end

	// Carries out one request on the local table and returns what the block should answer.
	function automatic hash_result_t apply_request(input lpht_pkg::op_t code,
			input logic [63:0] ha, input logic [63:0] hb, input logic [63:0] itm);
		hash_result_t r;
		logic [lpht_pkg::IDX_W-1:0] ix;
		int where;
		bit zero_key;
		bit ok;
		r = '0;
		zero_key = (ha == 0 && hb == 0);
		where = 0;
		ix = ha[lpht_pkg::IDX_W-1:0];
		if (!zero_key) begin
			for (int n = 0; n < lpht_pkg::BUCKETS && where == 0; n++) begin
				if (key_a[ix] == 0 && key_b[ix] == 0)
					where = 2;
				else if (key_a[ix] == ha && key_b[ix] == hb)
					where = 1;
				else
					ix = ix + 1'b1;
			end
		end
		if (code == lpht_pkg::OP_GET || code == lpht_pkg::OP_REMOVE) begin
			if (!zero_key && where == 1 && used[ix]) begin
				r.found = 1'b1;
				r.item = value[ix];
				if (code == lpht_pkg::OP_REMOVE) begin
					value[ix] = '0;
					used[ix] = 1'b0;
					gone[ix] = 1'b1;
					removed_cnt++;
				end
			end
		end else if (!zero_key) begin
			ok = 1'b1;
			if (where == 0) begin
				ok = 1'b0;
			end else if (where == 2) begin
				if (reserved_cnt >= limit) begin
					ok = 1'b0;
				end else begin
					key_a[ix] = ha;
					key_b[ix] = hb;
					value[ix] = '0;
					used[ix] = 1'b0;
					gone[ix] = 1'b0;
					reserved_cnt++;
				end
			end
			if (!ok) begin
				r.full = 1'b1;
			end else if (code == lpht_pkg::OP_PUT_IF_EMPTY && used[ix]) begin
				r.found = 1'b1;
				r.item = value[ix];
			end else begin
				r.found = used[ix];
				r.item = (code == lpht_pkg::OP_PUT_IF_EMPTY) ? itm : value[ix];
				r.stored = (code == lpht_pkg::OP_PUT_IF_EMPTY);
				value[ix] = itm;
				used[ix] = 1'b1;
				if (gone[ix]) begin
					gone[ix] = 1'b0;
					removed_cnt--;
				end
			end
		end
		r.live = 9'(reserved_cnt - removed_cnt);
		return r;
	endfunction

	always @(posedge clk) begin
		hash_result_t want;
		hash_result_t got;
		if (arst_n) begin
			if (load_limit_we)
				limit = load_limit_wdata;
			if (in_valid && in_ready)
				awaited.push_back(apply_request(lpht_pkg::op_t'(op), hash_low, hash_high,
					item_in));
			if (out_valid && out_ready) begin
				got = '{found, item_out, stored, table_full, live_count};
				if (awaited.size() == 0) begin
					mismatches++;
					$display("%0t: result expected none actual %h", $time, got);
				end else begin
					want = awaited.pop_front();
					if (got.found !== want.found) begin
						mismatches++;
						$display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
					end
					if (got.item !== want.item) begin
						mismatches++;
						$display("%0t: item_out expected %h actual %h", $time, want.item, got.item);
					end
					if (got.stored !== want.stored) begin
						mismatches++;
						$display("%0t: stored expected %0d actual %0d", $time, want.stored,
							got.stored);
					end
					if (got.full !== want.full) begin
						mismatches++;
						$display("%0t: table_full expected %0d actual %0d", $time, want.full,
							got.full);
					end
					if (got.live !== want.live) begin
						mismatches++;
						$display("%0t: live_count expected %0d actual %0d", $time, want.live,
							got.live);
					end
				end
			end
			pending = awaited.size();
		end
	end
endmodule

// ----- sim/linear_probe_hash_table_top_tb.sv -----
// Testbench top for the linear probe hash table: clock, reset, request and result
// stimulus with idling, load limit writes and the verdict.
// Depends on lpht_pkg, linear_probe_hash_table_top and lpht_result_check.
module linear_probe_hash_table_top_tb;
	localparam int POOL = 48;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  op;
	logic [63:0] hash_low;
	logic [63:0] hash_high;
	logic [63:0] item_in;
	logic        out_valid;
	logic        out_ready;
	logic        found;
	logic [63:0] item_out;
	logic        stored;
	logic        table_full;
	logic [8:0]  live_count;
	logic        load_limit_we;
	logic [8:0]  load_limit_wdata;
	int          mismatches;
	int          pending;

	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_asks;
	int          hold_seen;
	int          hold_left;
	int          requests_sent;
	logic [63:0] pool_lo [POOL];
	logic [63:0] pool_hi [POOL];

	linear_probe_hash_table_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .hash_low(hash_low), .hash_high(hash_high), .item_in(item_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .item_out(item_out), .stored(stored), .table_full(table_full),
		.live_count(live_count),
		.load_limit_we(load_limit_we), .load_limit_wdata(load_limit_wdata)
	);

	lpht_result_check scoreboard (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .hash_low(hash_low), .hash_high(hash_high), .item_in(item_in),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .item_out(item_out), .stored(stored), .table_full(table_full),
		.live_count(live_count),
		.load_limit_we(load_limit_we), .load_limit_wdata(load_limit_wdata),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off whenever the stimulus asks for one.
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			hold_left = 400;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	initial begin
		#30000000;
		$display("status: fail");
		$finish;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// Entered and left just after a falling edge; valid stays up between back-to-back requests.
	task automatic send(input lpht_pkg::op_t code, input logic [63:0] ha,
			input logic [63:0] hb, input logic [63:0] itm);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		hash_low <= ha;
		hash_high <= hb;
		item_in <= itm;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
		@(negedge clk);
	endtask

	task automatic random_request(input bit fresh_put);
		int pick;
		int k;
		logic [63:0] ha;
		logic [63:0] hb;
		logic [63:0] itm;
		pick = $urandom_range(0, 99);
		k = $urandom_range(0, POOL - 1);
		if (fresh_put || (pick >= 85 && pick < 97)) begin
			ha = rand64();
			hb = rand64();
		end else if (pick >= 97) begin
			ha = '0;
			hb = '0;
		end else begin
			ha = pool_lo[k];
			hb = pool_hi[k];
		end
		pick = $urandom_range(0, 99);
		itm = (pick < 5) ? '0 : (pick < 10) ? '1 : rand64();
		if (fresh_put)
			send(($urandom_range(0, 3) == 0) ? lpht_pkg::OP_PUT_IF_EMPTY : lpht_pkg::OP_PUT,
				ha, hb, itm);
		else
			send(lpht_pkg::op_t'($urandom_range(0, 3)), ha, hb, itm);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic set_limit(input logic [8:0] v);
		drain();
		load_limit_we <= 1'b1;
		load_limit_wdata <= v;
		@(negedge clk);
		load_limit_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = lpht_pkg::OP_GET;
		hash_low = '0;
		hash_high = '0;
		item_in = '0;
		out_ready = 1'b0;
		load_limit_we = 1'b0;
		load_limit_wdata = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_asks = 0;
		hold_seen = 0;
		hold_left = 0;
		requests_sent = 0;
		// Clustered start buckets and some keys sharing a first word make probing interesting.
		for (int i = 0; i < POOL; i++) begin
			pool_hi[i] = rand64();
			if (i > 0 && $urandom_range(0, 4) == 0)
				pool_lo[i] = pool_lo[i - 1];
			else if ($urandom_range(0, 1))
				pool_lo[i] = (rand64() << 8) | 64'($urandom_range(0, 7));
			else
				pool_lo[i] = (rand64() << 8) | 64'(8'hFC) | 64'($urandom_range(0, 3));
		end
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset load limit.
		send(lpht_pkg::OP_GET, '0, '0, '0);
		send(lpht_pkg::OP_PUT, '0, '0, 64'h1234);
		send(lpht_pkg::OP_PUT_IF_EMPTY, '0, '0, 64'h1234);
		send(lpht_pkg::OP_REMOVE, '0, '0, '0);
		send(lpht_pkg::OP_GET, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_PUT, 64'h55, 64'h1, '1);
		send(lpht_pkg::OP_GET, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_PUT_IF_EMPTY, 64'h55, 64'h1, 64'h77);
		send(lpht_pkg::OP_PUT, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_REMOVE, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_GET, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_REMOVE, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_PUT_IF_EMPTY, 64'h55, 64'h1, 64'h99);
		send(lpht_pkg::OP_REMOVE, 64'h55, 64'h1, '0);
		send(lpht_pkg::OP_PUT, 64'h55, 64'h1, 64'hABCD);
		send(lpht_pkg::OP_PUT, '1, '1, '1);
		send(lpht_pkg::OP_PUT_IF_EMPTY, 64'hFF, '0, 64'h5);
		send(lpht_pkg::OP_PUT_IF_EMPTY, 64'hFF, 64'h2, 64'h6);
		send(lpht_pkg::OP_GET, 64'hFF, 64'h2, '0);
		send(lpht_pkg::OP_GET, 64'hFF, 64'h3, '0);
		send(lpht_pkg::OP_REMOVE, '1, '1, '0);

		send_idle_pct = 12;
		recv_idle_pct = 86;
		set_limit(9'd1);
		repeat (60) random_request(1'b0);
		set_limit(9'($urandom_range(2, 255)));
		repeat (100) random_request(1'b0);

		send_idle_pct = 86;
		recv_idle_pct = 12;
		set_limit(9'd40);
		repeat (100) random_request(1'b0);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_limit(9'd256);
		hold_asks++;
		repeat (100) random_request(1'b0);
		// Claim every bucket, then keep asking so that puts find no free bucket.
		repeat (270) random_request(1'b1);
		repeat (40) random_request(1'b0);
		set_limit(9'd192);
		repeat (20) random_request(1'b0);

		drain();
		repeat (20) @(negedge clk);
		$display("Covered %0d requests: zero keys, removal and revival, wrapping probes,",
			requests_sent);
		$display("load limits 1 to 256, a fully claimed table and long result stalls.");
		if (mismatches == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
